[hdl/lcmb_pkg.sv]
// Shared constants and types for the three-period least common multiple search block.
package lcmb_pkg;

	// Width of the multiple and of each count in a result item.
	localparam int unsigned RES_BITS = 32;

	// Result payload: found flag, multiple and three counts, padded to whole bytes.
	localparam int unsigned OUT_BITS = ((1 + 4 * RES_BITS + 7) / 8) * 8;

	// Width and reset value of the iteration limit register.
	localparam int unsigned LIMIT_BITS = 16;
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd10000;

	// Sequencer state codes.
	localparam int unsigned ST_BITS = 3;
	localparam logic [ST_BITS-1:0] ST_IDLE   = 3'd0;
	localparam logic [ST_BITS-1:0] ST_DIV    = 3'd1;
	localparam logic [ST_BITS-1:0] ST_INIT   = 3'd2;
	localparam logic [ST_BITS-1:0] ST_SEARCH = 3'd3;
	localparam logic [ST_BITS-1:0] ST_DONE   = 3'd4;

	// Lane selector for the three periods.
	typedef logic [1:0] lane_t;
	localparam lane_t LANE_A = 2'd0;
	localparam lane_t LANE_B = 2'd1;
	localparam lane_t LANE_C = 2'd2;

	// Full-width multiple and count types.
	typedef logic [RES_BITS:0]   multiple_t;
	typedef logic [RES_BITS-1:0] count_t;

endpackage

[hdl/lcm_of_three_bounded_search_top.sv]
// Least common multiple of three periods found by a bounded search over multiples of the largest.
//
// Usage: an input item on the s_ channel carries three periods. The block searches
// the multiples big*k of the largest period for k = 1 .. iteration_limit-1 and emits
// one result item on the m_ channel: a found flag, the multiple and the multiple
// divided by each period. A zero period, an exhausted search or a multiple wider
// than 32 bits gives found = 0 with all other fields zero.
// Operation: one shared restoring divider (one quotient bit a cycle) runs once per
// period to get big / p and big % p; then one trial multiple a cycle is checked
// using running remainders and running quotients. A zero period skips straight
// to the result.
// Throughput: one item at a time; s_tready is high only while the sequencer idles.
// The result sits in an output register, so the next item is accepted while a
// result still waits; if the receiver stalls, the next result waits in the
// sequencer until the register frees.
// Reset: arst_n clears the sequencer and output valid and sets iteration_limit to 10000.
// cfg_we writes cfg_wdata into iteration_limit; write it only while the block idles.
module lcm_of_three_bounded_search_top
	import lcmb_pkg::*;
#(
	parameter int unsigned PERIOD_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write port for iteration_limit.
	input  logic                  cfg_we,
	input  logic [LIMIT_BITS-1:0] cfg_wdata,
	// Input items. tdata fields from bit 0: period_a, period_b, period_c.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [((3*PERIOD_BITS+7)/8)*8-1:0] s_tdata,
	// Result items. tdata fields from bit 0: found, common_multiple, count_a,
	// count_b, count_c, zero padding.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_BITS-1:0]   m_tdata
);

	localparam int unsigned PB = PERIOD_BITS;
	localparam int unsigned CW = (PB > 1) ? $clog2(PB) : 1;

	typedef logic [PB-1:0] period_t;

	// Control and configuration registers.
	logic [ST_BITS-1:0]    state_q;
	logic [LIMIT_BITS-1:0] limit_q;
	logic                  found_q;
	logic                  out_valid_q;
	logic [OUT_BITS-1:0]   out_data_q;

	// Operand and search registers.
	period_t               per_q [3];
	period_t               big_q;
	lane_t                 sel_q;
	logic [CW-1:0]         bit_cnt_q;
	period_t               div_rem_q;
	period_t               div_dvd_q;
	period_t               quo_q [3];
	period_t               mod_q [3];
	period_t               rem_q [3];
	count_t                cnt_q [3];
	multiple_t             mult_q;
	logic [LIMIT_BITS-1:0] k_q;

	// Input fields and the largest period.
	period_t in_a, in_b, in_c, in_big;
	logic    in_zero;

	assign in_a    = s_tdata[PB-1:0];
	assign in_b    = s_tdata[2*PB-1:PB];
	assign in_c    = s_tdata[3*PB-1:2*PB];
	assign in_zero = (in_a == '0) || (in_b == '0) || (in_c == '0);

	always_comb begin
		period_t tmp;
		tmp    = (in_a > in_b) ? in_a : in_b;
		in_big = (in_c > tmp) ? in_c : tmp;
	end

	// Shared restoring divider step: one quotient bit of big / per[sel] a cycle.
	period_t       div_sor;
	logic [PB:0]   rem_sh;
	logic [PB:0]   rem_sub;
	logic          div_ge;
	period_t       rem_nx;
	period_t       dvd_nx;

	always_comb begin
		case (sel_q)
			LANE_A:  div_sor = per_q[0];
			LANE_B:  div_sor = per_q[1];
			default: div_sor = per_q[2];
		endcase
		rem_sh  = {div_rem_q, div_dvd_q[PB-1]};
		rem_sub = rem_sh - {1'b0, div_sor};
		div_ge  = (rem_sh >= {1'b0, div_sor});
		rem_nx  = div_ge ? rem_sub[PB-1:0] : rem_sh[PB-1:0];
		dvd_nx  = {div_dvd_q[PB-2:0], div_ge};
	end

	// Running remainder and quotient update per lane for the next trial multiple.
	period_t rem_step [3];
	count_t  cnt_step [3];
	logic    all_zero;

	always_comb begin
		logic [PB:0] sum;
		logic        wrap;
		for (int i = 0; i < 3; i++) begin
			sum         = {1'b0, rem_q[i]} + {1'b0, mod_q[i]};
			wrap        = (sum >= {1'b0, per_q[i]});
			rem_step[i] = wrap ? PB'(sum - {1'b0, per_q[i]}) : sum[PB-1:0];
			cnt_step[i] = cnt_q[i] + RES_BITS'(quo_q[i]) + RES_BITS'(wrap);
		end
		all_zero = (rem_q[0] == '0) && (rem_q[1] == '0) && (rem_q[2] == '0);
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// Output valid: set when a result is loaded, cleared when the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!out_valid_q || m_tready)) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Sequencer: divide phase, search phase, result hand-off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			found_q     <= 1'b0;
			sel_q       <= LANE_A;
			bit_cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						found_q   <= 1'b0;
						sel_q     <= LANE_A;
						bit_cnt_q <= '0;
						state_q   <= in_zero ? ST_DONE : ST_DIV;
					end
				end
				ST_DIV: begin
					if (bit_cnt_q == CW'(PB - 1)) begin
						bit_cnt_q <= '0;
						if (sel_q == LANE_C) begin
							state_q <= ST_INIT;
						end else begin
							sel_q <= sel_q + 2'd1;
						end
					end else begin
						bit_cnt_q <= bit_cnt_q + CW'(1);
					end
				end
				ST_INIT: begin
					state_q <= ST_SEARCH;
				end
				ST_SEARCH: begin
					if (k_q >= limit_q || mult_q[RES_BITS]) begin
						state_q <= ST_DONE;
					end else if (all_zero) begin
						found_q <= 1'b1;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					per_q[0]  <= in_a;
					per_q[1]  <= in_b;
					per_q[2]  <= in_c;
					big_q     <= in_big;
					div_rem_q <= '0;
					div_dvd_q <= in_big;
				end
			end
			ST_DIV: begin
				if (bit_cnt_q == CW'(PB - 1)) begin
					quo_q[sel_q] <= dvd_nx;
					mod_q[sel_q] <= rem_nx;
					div_rem_q    <= '0;
					div_dvd_q    <= big_q;
				end else begin
					div_rem_q <= rem_nx;
					div_dvd_q <= dvd_nx;
				end
			end
			ST_INIT: begin
				// First trial: k = 1, multiple = big.
				mult_q <= (RES_BITS + 1)'(big_q);
				k_q    <= LIMIT_BITS'(1);
				for (int i = 0; i < 3; i++) begin
					rem_q[i] <= mod_q[i];
					cnt_q[i] <= RES_BITS'(quo_q[i]);
				end
			end
			ST_SEARCH: begin
				if (!(k_q >= limit_q || mult_q[RES_BITS] || all_zero)) begin
					mult_q <= mult_q + (RES_BITS + 1)'(big_q);
					k_q    <= k_q + LIMIT_BITS'(1);
					for (int i = 0; i < 3; i++) begin
						rem_q[i] <= rem_step[i];
						cnt_q[i] <= cnt_step[i];
					end
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					if (found_q) begin
						out_data_q <= OUT_BITS'({cnt_q[2], cnt_q[1], cnt_q[0],
							mult_q[RES_BITS-1:0], 1'b1});
					end else begin
						out_data_q <= '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule
